// File: src/uer_pkg.sv
// types and constants shared by the echo ranger modules
package uer_pkg;

	localparam int ActW     = 2;
	localparam int CapW     = 16;
	localparam int DistW    = 19;
	localparam int TmoW     = 16;
	localparam int CfgAddrW = 2;

	typedef enum logic [ActW-1:0] {
		ACT_POLL = 2'd0,
		ACT_RISE = 2'd1,
		ACT_FALL = 2'd2,
		ACT_TICK = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OC_NONE    = 2'd0,
		OC_VALID   = 2'd1,
		OC_RANGE   = 2'd2,
		OC_TIMEOUT = 2'd3
	} outcome_t;

	localparam logic [CfgAddrW-1:0] REG_MIN_RANGE  = 2'd0;
	localparam logic [CfgAddrW-1:0] REG_MAX_RANGE  = 2'd1;
	localparam logic [CfgAddrW-1:0] REG_TIMEOUT_MS = 2'd2;

	localparam logic [DistW-1:0] MinRangeRst  = 19'd512;
	localparam logic [DistW-1:0] MaxRangeRst  = 19'd102400;
	localparam logic [TmoW-1:0]  TimeoutMsRst = 16'd50;

	// distance = round(width * 4.352) = floor((width * 544 + 62) / 125)
	localparam int NumW       = 26;
	localparam int LoW        = 17;
	localparam int RecipW     = 27;
	localparam int ProdW      = NumW + RecipW;
	localparam int RecipShift = 33;
	localparam logic [RecipW-1:0] RecipMul  = 27'd68719477;
	localparam logic [NumW-1:0]   RoundOff  = 26'd62;
	localparam logic [31:0]       SatWidth  = 32'd120471;

	typedef struct packed {
		logic              trigger_request;
		outcome_t          outcome;
		logic [DistW-1:0]  distance_out;
		logic              distance_valid;
		logic              busy_res;
	} result_t;

endpackage

// File: src/uer_in_if.sv
// event channel: action and captured timer value
interface uer_in_if import uer_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ActW-1:0] action;
	logic [CapW-1:0] capture_value;

	modport source(output valid, output action, output capture_value, input ready);
	modport sink(input valid, input action, input capture_value, output ready);
endinterface

// File: src/uer_out_if.sv
// result channel: trigger, outcome and distance report
interface uer_out_if import uer_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             trigger_request;
	logic [1:0]       outcome;
	logic [DistW-1:0] distance_out;
	logic             distance_valid;
	logic             busy_res;

	modport source(output valid, output trigger_request, output outcome, output distance_out,
		output distance_valid, output busy_res, input ready);
	modport sink(input valid, input trigger_request, input outcome, input distance_out,
		input distance_valid, input busy_res, output ready);
endinterface

// File: src/ultrasonic_echo_ranger.sv
// echo ranger top level: event input register, control core, result register
// an accepted event is held in the input register, then its report in the result register
// throughput: one event per cycle while reports are taken; a falling-edge capture converts
// width to distance with one 26x27 reciprocal multiply, a poll compares to range and timeout
// reset: asynchronous, clears measurement state and returns the range and timeout
// registers to their defaults; no clearing pass, events are taken right after reset
module ultrasonic_echo_ranger import uer_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [DistW-1:0]    cfg_data,
	uer_in_if.sink              evt,
	uer_out_if.source           rpt
);

	logic            v_s1, v_s2;
	action_t         act_s1;
	logic [CapW-1:0] cap_s1;
	result_t         res_d, res_s2;
	logic            adv, step;

	assign adv       = !v_s2 || rpt.ready;
	assign step      = v_s1 && adv;
	assign evt.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (evt.ready)
				v_s1 <= evt.valid;
			if (adv)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			act_s1 <= action_t'(evt.action);
			cap_s1 <= evt.capture_value;
		end
		if (step)
			res_s2 <= res_d;
	end

	uer_core #(.TIMER_BITS(TIMER_BITS)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.step    (step),
		.act     (act_s1),
		.cap     (cap_s1),
		.res     (res_d)
	);

	assign rpt.valid           = v_s2;
	assign rpt.trigger_request = res_s2.trigger_request;
	assign rpt.outcome         = res_s2.outcome;
	assign rpt.distance_out    = res_s2.distance_out;
	assign rpt.distance_valid  = res_s2.distance_valid;
	assign rpt.busy_res        = res_s2.busy_res;

endmodule

// File: src/uer_dist_conv.sv
// echo width to distance in 1/256 cm with saturation
module uer_dist_conv import uer_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic [TIMER_BITS-1:0] width,
	output logic [DistW-1:0]      distance
);

	logic [31:0]      w_ext;
	logic [LoW-1:0]   w_lo;
	logic             sat;
	logic [NumW-1:0]  num;
	logic [ProdW-1:0] prod;

	always_comb begin
		w_ext    = 32'(width);
		sat      = (w_ext >= SatWidth);
		w_lo     = w_ext[LoW-1:0];
		num      = NumW'({w_lo, 9'b0}) + NumW'({w_lo, 5'b0}) + RoundOff;
		prod     = ProdW'(num) * ProdW'(RecipMul);
		distance = sat ? '1 : prod[RecipShift +: DistW];
	end

endmodule

// File: src/uer_core.sv
// measurement state, configuration registers and result decode
module uer_core import uer_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [DistW-1:0]    cfg_data,
	input  logic                step,
	input  action_t             act,
	input  logic [CapW-1:0]     cap,
	output result_t             res
);

	logic [DistW-1:0]      min_range_q, max_range_q;
	logic [TmoW-1:0]       timeout_ms_q;
	logic                  measuring_q, echo_seen_q, last_valid_q;
	logic [TIMER_BITS-1:0] rise_time_q;
	logic [DistW-1:0]      echo_dist_q, last_distance_q;
	logic [TmoW-1:0]       elapsed_q;

	logic                  measuring_d, echo_seen_d, last_valid_d;
	logic [TIMER_BITS-1:0] rise_time_d, cap_t, width;
	logic [DistW-1:0]      echo_dist_d, last_distance_d, conv_dist;
	logic [TmoW-1:0]       elapsed_d;
	logic                  trig;
	outcome_t              oc;

	assign cap_t = TIMER_BITS'(cap);
	assign width = cap_t - rise_time_q;

	uer_dist_conv #(.TIMER_BITS(TIMER_BITS)) u_conv (
		.width   (width),
		.distance(conv_dist)
	);

	always_comb begin
		measuring_d     = measuring_q;
		echo_seen_d     = echo_seen_q;
		last_valid_d    = last_valid_q;
		rise_time_d     = rise_time_q;
		echo_dist_d     = echo_dist_q;
		last_distance_d = last_distance_q;
		elapsed_d       = elapsed_q;
		trig            = 1'b0;
		oc              = OC_NONE;
		case (act)
			ACT_POLL: begin
				if (!measuring_q) begin
					measuring_d  = 1'b1;
					echo_seen_d  = 1'b0;
					last_valid_d = 1'b0;
					elapsed_d    = '0;
					trig         = 1'b1;
				end else if (echo_seen_q) begin
					if (echo_dist_q >= min_range_q && echo_dist_q <= max_range_q) begin
						last_distance_d = echo_dist_q;
						last_valid_d    = 1'b1;
						oc              = OC_VALID;
					end else begin
						last_valid_d = 1'b0;
						oc           = OC_RANGE;
					end
					echo_seen_d = 1'b0;
					measuring_d = 1'b0;
				end else if (elapsed_q > timeout_ms_q) begin
					last_distance_d = max_range_q;
					last_valid_d    = 1'b0;
					echo_seen_d     = 1'b0;
					measuring_d     = 1'b0;
					oc              = OC_TIMEOUT;
				end
			end
			ACT_RISE: begin
				if (measuring_q)
					rise_time_d = cap_t;
			end
			ACT_FALL: begin
				if (measuring_q) begin
					echo_dist_d = conv_dist;
					echo_seen_d = 1'b1;
				end
			end
			default: begin
				if (elapsed_q != '1)
					elapsed_d = elapsed_q + 1'b1;
			end
		endcase
		res.trigger_request = trig;
		res.outcome         = oc;
		res.distance_out    = last_distance_d;
		res.distance_valid  = last_valid_d;
		res.busy_res        = measuring_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q  <= MinRangeRst;
			max_range_q  <= MaxRangeRst;
			timeout_ms_q <= TimeoutMsRst;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MIN_RANGE:  min_range_q  <= cfg_data;
				REG_MAX_RANGE:  max_range_q  <= cfg_data;
				REG_TIMEOUT_MS: timeout_ms_q <= cfg_data[TmoW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measuring_q     <= 1'b0;
			echo_seen_q     <= 1'b0;
			last_valid_q    <= 1'b0;
			rise_time_q     <= '0;
			echo_dist_q     <= '0;
			last_distance_q <= '0;
			elapsed_q       <= '0;
		end else if (step) begin
			measuring_q     <= measuring_d;
			echo_seen_q     <= echo_seen_d;
			last_valid_q    <= last_valid_d;
			rise_time_q     <= rise_time_d;
			echo_dist_q     <= echo_dist_d;
			last_distance_q <= last_distance_d;
			elapsed_q       <= elapsed_d;
		end
	end

endmodule
